// ----- hdl/lbrs_pkg.sv -----
package lbrs_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef struct packed {
    key_t key;
    logic last_key;
  } in_word_t;

  typedef struct packed {
    key_t sorted_key;
    logic last_out;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ZERO  = 4'b0010,
    ST_ONE   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

// ----- hdl/lsd_binary_radix_sort.sv -----
// After the word flagged last: P passes, each scanning the N stored keys twice, then one
//   output scan, where N is the stored key count and P the bit length of the largest key.
// Throughput: one word per cycle while loading; busy stays high from the last word of a
//   set until its final result, set by the single read port that each pass scans twice.
// Reset: synchronous, active high; clears the count, largest key and control state.
// Results appear for one cycle each on strobe; the receiver cannot stall them.
module lsd_binary_radix_sort
  import lbrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      strobe,
  output out_word_t result
);

  key_t mem0 [CAPACITY];
  key_t mem1 [CAPACITY];
  key_t rdata0;
  key_t rdata1;

  state_t    state;
  logic      sel;
  cnt_t      count;
  key_t      largest;
  key_t      rem;
  key_t      mask;
  cnt_t      rd_idx;
  logic      rd_vld;
  logic      rd_last;
  cnt_t      wr_idx;
  out_word_t result_q;
  logic      strobe_q;

  logic  we0;
  logic  we1;
  addr_t waddr;
  key_t  wdata;
  key_t  rd_data;
  logic  rd_bit;
  logic  take;
  logic  can_store;
  key_t  largest_next;
  logic  scan_done;

  assign busy      = (state != ST_IDLE);
  assign strobe    = strobe_q;
  assign result    = result_q;
  assign rd_data   = sel ? rdata1 : rdata0;
  assign rd_bit    = |(rd_data & mask);
  assign can_store = (count < cnt_t'(CAPACITY));
  assign scan_done = (rd_idx == count) && !rd_vld;

  always_comb begin
    largest_next = largest;
    if (can_store && (in_word.key > largest)) begin
      largest_next = in_word.key;
    end
  end

  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = count[ADDR_W-1:0];
    wdata = in_word.key;
    take  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start && can_store) begin
          we0 = !sel;
          we1 = sel;
        end
      end
      ST_ZERO, ST_ONE: begin
        // zero-bit keys first, then one-bit keys, into the other memory
        take  = rd_vld && ((state == ST_ONE) ? rd_bit : !rd_bit);
        waddr = wr_idx[ADDR_W-1:0];
        wdata = rd_data;
        we0   = take && sel;
        we1   = take && !sel;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    rdata0 <= mem0[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rdata1 <= mem1[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    result_q.sorted_key <= rd_data;
    result_q.last_out   <= rd_last;
    if (rst) begin
      state    <= ST_IDLE;
      sel      <= 1'b0;
      count    <= '0;
      largest  <= '0;
      rem      <= '0;
      mask     <= '0;
      rd_idx   <= '0;
      rd_vld   <= 1'b0;
      rd_last  <= 1'b0;
      wr_idx   <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (state == ST_EMIT) && rd_vld;
      unique case (state)
        ST_IDLE: begin
          rd_idx <= '0;
          rd_vld <= 1'b0;
          wr_idx <= '0;
          if (start) begin
            if (can_store) begin
              count <= count + cnt_t'(1);
            end
            largest <= largest_next;
            if (in_word.last_key) begin
              rem   <= largest_next;
              mask  <= key_t'(1);
              state <= ST_ZERO;
            end
          end
        end
        ST_ZERO, ST_ONE: begin
          if (take) begin
            wr_idx <= wr_idx + cnt_t'(1);
          end
          if (scan_done) begin
            rd_idx <= '0;
            if (state == ST_ZERO) begin
              state <= ST_ONE;
            end else begin
              sel    <= !sel;
              wr_idx <= '0;
              rem    <= rem >> 1;
              mask   <= mask << 1;
              state  <= (rem[KEY_BITS-1:1] == '0) ? ST_EMIT : ST_ZERO;
            end
          end else if (rd_idx != count) begin
            rd_idx <= rd_idx + cnt_t'(1);
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (scan_done) begin
            count   <= '0;
            largest <= '0;
            state   <= ST_IDLE;
          end else if (rd_idx != count) begin
            rd_idx  <= rd_idx + cnt_t'(1);
            rd_vld  <= 1'b1;
            rd_last <= ((rd_idx + cnt_t'(1)) == count);
          end else begin
            rd_vld <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_last_ends_set: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_out |=> state == ST_IDLE)
    else $error("set not closed after final result");

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_EMIT))
    else $error("result strobe outside output phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(CAPACITY))
    else $error("key count beyond capacity");

  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ZERO || state == ST_ONE) |-> wr_idx <= count)
    else $error("split write index beyond key count");

endmodule
